// ----- rtl/crp_pkg.sv -----
// ----------------------------------------------------------------------------
// crp_pkg
// shared widths, register indexes and the work beat passed from front to back
// ----------------------------------------------------------------------------
package crp_pkg;

    localparam int PosW    = 24;
    localparam int VelW    = 17;
    localparam int RadW    = 10;
    localparam int TimeW   = 16;
    localparam int FracW   = 10;
    localparam int GapW    = 11;
    localparam int SpdW    = 10;
    localparam int RpW     = PosW + 1;
    localparam int RvW     = VelW + 1;
    localparam int CombW   = RadW + 1;
    localparam int EsqW    = 2 * VelW;
    localparam int DotW    = 44;
    localparam int VsqW    = 36;
    localparam int RemW    = DotW + FracW;
    localparam int MulW    = RvW + TimeW + 1;
    localparam int CW      = 26;
    localparam int DsqW    = 2 * CW;
    localparam int SqW     = 2 * GapW;
    localparam int SqRemW  = GapW + 3;

    localparam int InDataW  = 136;
    localparam int OutDataW = 32;
    localparam int CfgIdxW  = 8;
    localparam int CfgDataW = 16;

    localparam int FifoDepth = 4;
    localparam int FifoAw    = 2;

    localparam logic [CfgIdxW-1:0] REG_HORIZON   = 8'd0;
    localparam logic [CfgIdxW-1:0] REG_MIN_SPEED = 8'd1;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_CHECK = 1'b1;

    localparam logic [TimeW-1:0] HORIZON_RESET   = 16'd3072;
    localparam logic [SpdW-1:0]  MIN_SPEED_RESET = 10'd5;

    typedef struct packed {
        logic                  chk;
        logic signed [RpW-1:0] rp_x;
        logic signed [RpW-1:0] rp_y;
        logic signed [RpW-1:0] rp_z;
        logic signed [RvW-1:0] rv_x;
        logic signed [RvW-1:0] rv_y;
        logic signed [RvW-1:0] rv_z;
        logic [CombW-1:0]      comb;
    } work_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_status_t;

endpackage

// ----- rtl/crp_front.sv -----
// ----------------------------------------------------------------------------
// crp_front
// holds the ego, classifies each beat and forms relative position and velocity
// ----------------------------------------------------------------------------
module crp_front
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        in_opcode,
    input  logic signed [23:0]          in_pos_x,
    input  logic signed [23:0]          in_pos_y,
    input  logic signed [23:0]          in_pos_z,
    input  logic signed [16:0]          in_vel_x,
    input  logic signed [16:0]          in_vel_y,
    input  logic signed [16:0]          in_vel_z,
    input  logic [9:0]                  in_radius,
    input  logic [crp_pkg::SpdW-1:0]    min_speed,
    input  crp_pkg::fifo_status_t       fifo_status,
    output logic                        push,
    output crp_pkg::work_t              work
);

    logic                                   fv_reg;
    crp_pkg::work_t                         work_reg;
    crp_pkg::work_t                         work_next;
    logic signed [crp_pkg::PosW-1:0]        ego_pos_x_reg, ego_pos_y_reg, ego_pos_z_reg;
    logic signed [crp_pkg::VelW-1:0]        ego_vel_x_reg, ego_vel_y_reg, ego_vel_z_reg;
    logic [crp_pkg::RadW-1:0]               ego_radius_reg;
    logic                                   ego_loaded_reg;
    logic [crp_pkg::EsqW-1:0]               esq_reg;
    logic [crp_pkg::EsqW-1:0]               esq_next;
    logic signed [crp_pkg::EsqW-1:0]        sq_x, sq_y, sq_z;
    logic [2*crp_pkg::SpdW-1:0]             min_sq;
    logic                                   accept;

    assign in_ready = !fv_reg || !fifo_status.full;
    assign accept   = in_valid && in_ready;
    assign push     = fv_reg && !fifo_status.full;
    assign work     = work_reg;

    // ego speed squared is taken once, when the ego is loaded
    always_comb
    begin
        sq_x     = in_vel_x * in_vel_x;
        sq_y     = in_vel_y * in_vel_y;
        sq_z     = in_vel_z * in_vel_z;
        esq_next = $unsigned(sq_x) + $unsigned(sq_y) + $unsigned(sq_z);
        min_sq   = min_speed * min_speed;

        work_next.chk  = (in_opcode == crp_pkg::OP_CHECK) && ego_loaded_reg
                         && (esq_reg >= crp_pkg::EsqW'(min_sq));
        work_next.rp_x = crp_pkg::RpW'(in_pos_x) - crp_pkg::RpW'(ego_pos_x_reg);
        work_next.rp_y = crp_pkg::RpW'(in_pos_y) - crp_pkg::RpW'(ego_pos_y_reg);
        work_next.rp_z = crp_pkg::RpW'(in_pos_z) - crp_pkg::RpW'(ego_pos_z_reg);
        work_next.rv_x = crp_pkg::RvW'(in_vel_x) - crp_pkg::RvW'(ego_vel_x_reg);
        work_next.rv_y = crp_pkg::RvW'(in_vel_y) - crp_pkg::RvW'(ego_vel_y_reg);
        work_next.rv_z = crp_pkg::RvW'(in_vel_z) - crp_pkg::RvW'(ego_vel_z_reg);
        work_next.comb = crp_pkg::CombW'(in_radius) + crp_pkg::CombW'(ego_radius_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fv_reg         <= 1'b0;
            ego_pos_x_reg  <= '0;
            ego_pos_y_reg  <= '0;
            ego_pos_z_reg  <= '0;
            ego_vel_x_reg  <= '0;
            ego_vel_y_reg  <= '0;
            ego_vel_z_reg  <= '0;
            ego_radius_reg <= '0;
            ego_loaded_reg <= 1'b0;
            esq_reg        <= '0;
        end
        else
        begin
            if (accept)
                fv_reg <= 1'b1;
            else if (push)
                fv_reg <= 1'b0;
            if (accept && (in_opcode == crp_pkg::OP_LOAD))
            begin
                ego_pos_x_reg  <= in_pos_x;
                ego_pos_y_reg  <= in_pos_y;
                ego_pos_z_reg  <= in_pos_z;
                ego_vel_x_reg  <= in_vel_x;
                ego_vel_y_reg  <= in_vel_y;
                ego_vel_z_reg  <= in_vel_z;
                ego_radius_reg <= in_radius;
                ego_loaded_reg <= 1'b1;
                esq_reg        <= esq_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            work_reg <= work_next;
    end

endmodule

// ----- rtl/crp_fifo.sv -----
// ----------------------------------------------------------------------------
// crp_fifo
// short queue of work beats between front and back
// ----------------------------------------------------------------------------
module crp_fifo
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  crp_pkg::work_t          wr_data,
    input  logic                    pop,
    output crp_pkg::work_t          rd_data,
    output crp_pkg::fifo_status_t   status
);

    crp_pkg::work_t                 mem_reg [crp_pkg::FifoDepth];
    logic [crp_pkg::FifoAw-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [crp_pkg::FifoAw:0]       count_reg;

    assign rd_data      = mem_reg[rd_ptr_reg];
    assign status.full  = (count_reg == (crp_pkg::FifoAw+1)'(crp_pkg::FifoDepth));
    assign status.empty = (count_reg == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

// ----- rtl/crp_back.sv -----
// ----------------------------------------------------------------------------
// crp_back
// closest-approach pipeline: dot products, bit-per-stage divider, distance,
// pair-per-stage square root and the output register
// ----------------------------------------------------------------------------
module crp_back
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  crp_pkg::work_t              in_work,
    input  crp_pkg::fifo_status_t       fifo_status,
    output logic                        pop,
    input  logic [crp_pkg::TimeW-1:0]   horizon,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic                        out_alert,
    output logic [crp_pkg::TimeW-1:0]   out_time,
    output logic [crp_pkg::GapW-1:0]    out_gap
);

    typedef struct packed {
        logic                           chk;
        logic signed [crp_pkg::RpW-1:0] rp_x, rp_y, rp_z;
        logic signed [crp_pkg::RvW-1:0] rv_x, rv_y, rv_z;
        logic [crp_pkg::CombW-1:0]      comb;
    } geo_t;

    typedef struct packed {
        geo_t                               g;
        logic signed [crp_pkg::RpW+crp_pkg::RvW-1:0] pv_x, pv_y, pv_z;
        logic signed [crp_pkg::VsqW-1:0]    vv_x, vv_y, vv_z;
    } sa_t;

    typedef struct packed {
        geo_t                               g;
        logic signed [crp_pkg::DotW-1:0]    dot;
        logic [crp_pkg::VsqW-1:0]           vsq;
    } sb_t;

    typedef struct packed {
        geo_t                           g;
        logic                           sat;
        logic [crp_pkg::VsqW-1:0]       vsq;
        logic [crp_pkg::RemW-1:0]       rem;
        logic [crp_pkg::TimeW-1:0]      q;
    } div_t;

    typedef struct packed {
        geo_t                           g;
        logic [crp_pkg::TimeW-1:0]      t;
    } st_t;

    typedef struct packed {
        logic                              chk;
        logic signed [crp_pkg::RpW-1:0]    rp_x, rp_y, rp_z;
        logic signed [crp_pkg::MulW-1:0]   m_x, m_y, m_z;
        logic [crp_pkg::CombW-1:0]         comb;
        logic [crp_pkg::TimeW-1:0]         t;
    } sm_t;

    typedef struct packed {
        logic                           chk;
        logic signed [crp_pkg::CW-1:0]  c_x, c_y, c_z;
        logic [crp_pkg::CombW-1:0]      comb;
        logic [crp_pkg::TimeW-1:0]      t;
    } sc_t;

    typedef struct packed {
        logic                             chk;
        logic signed [crp_pkg::DsqW-1:0]  cc_x, cc_y, cc_z;
        logic [2*crp_pkg::CombW-1:0]      comb_sq;
        logic [crp_pkg::TimeW-1:0]        t;
    } sq2_t;

    typedef struct packed {
        logic                           alert;
        logic [crp_pkg::TimeW-1:0]      t;
        logic [crp_pkg::SqW-1:0]        x;
        logic [crp_pkg::SqRemW-1:0]     rem;
        logic [crp_pkg::GapW-1:0]       root;
    } rt_t;

    logic                   ce;
    logic                   va_reg, vb_reg, vt_reg, vm_reg, vc_reg, vq_reg, ov_reg;
    logic                   vd_reg [crp_pkg::TimeW+1];
    logic                   vr_reg [crp_pkg::GapW+1];
    sa_t                    sa_reg;
    sb_t                    sb_reg;
    div_t                   dv_reg [crp_pkg::TimeW+1];
    div_t                   dv_next [crp_pkg::TimeW+1];
    st_t                    st_reg;
    sm_t                    sm_reg;
    sc_t                    sc_reg;
    sq2_t                   sq_reg;
    rt_t                    rt_reg [crp_pkg::GapW+1];
    rt_t                    rt_next [crp_pkg::GapW+1];
    sa_t                    sa_next;
    sb_t                    sb_next;
    st_t                    st_next;
    sm_t                    sm_next;
    sc_t                    sc_next;
    sq2_t                   sq_next;
    logic                   out_alert_reg;
    logic [crp_pkg::TimeW-1:0] out_time_reg;
    logic [crp_pkg::GapW-1:0]  out_gap_reg;

    // whole pipeline moves when the output register is free or being drained
    assign ce        = !ov_reg || out_ready;
    assign pop       = ce && !fifo_status.empty;
    assign out_valid = ov_reg;
    assign out_alert = out_alert_reg;
    assign out_time  = out_time_reg;
    assign out_gap   = out_gap_reg;

    // products, sums
    always_comb
    begin
        sa_next.g    = geo_t'(in_work);
        sa_next.pv_x = in_work.rp_x * in_work.rv_x;
        sa_next.pv_y = in_work.rp_y * in_work.rv_y;
        sa_next.pv_z = in_work.rp_z * in_work.rv_z;
        sa_next.vv_x = in_work.rv_x * in_work.rv_x;
        sa_next.vv_y = in_work.rv_y * in_work.rv_y;
        sa_next.vv_z = in_work.rv_z * in_work.rv_z;

        sb_next.g   = sa_reg.g;
        sb_next.dot = crp_pkg::DotW'(sa_reg.pv_x) + crp_pkg::DotW'(sa_reg.pv_y)
                      + crp_pkg::DotW'(sa_reg.pv_z);
        sb_next.vsq = $unsigned(sa_reg.vv_x) + $unsigned(sa_reg.vv_y)
                      + $unsigned(sa_reg.vv_z);
    end

    // divider seed, then restoring divider, one quotient bit per stage, msb first
    always_comb
    begin
        logic [crp_pkg::DotW-1:0] num;
        logic [crp_pkg::RemW-1:0] trial;
        // only an approaching object has a positive time
        num = sb_reg.dot[crp_pkg::DotW-1] ? $unsigned(-sb_reg.dot) : '0;
        dv_next[0].g     = sb_reg.g;
        dv_next[0].g.chk = sb_reg.g.chk && (sb_reg.vsq != '0);
        dv_next[0].sat   = num >= crp_pkg::DotW'({sb_reg.vsq,
                                                  {(crp_pkg::TimeW-crp_pkg::FracW){1'b0}}});
        dv_next[0].vsq   = sb_reg.vsq;
        dv_next[0].rem   = {num, {crp_pkg::FracW{1'b0}}};
        dv_next[0].q     = '0;
        for (int k = 0; k < crp_pkg::TimeW; k++)
        begin
            trial = crp_pkg::RemW'(dv_reg[k].vsq) << (crp_pkg::TimeW - 1 - k);
            dv_next[k+1] = dv_reg[k];
            if (dv_reg[k].rem >= trial)
            begin
                dv_next[k+1].rem = dv_reg[k].rem - trial;
                dv_next[k+1].q[crp_pkg::TimeW-1-k] = 1'b1;
            end
        end
    end

    // clamp, motion, closest point, squared distance
    always_comb
    begin
        logic signed [crp_pkg::MulW-1:0] bias_x, bias_y, bias_z;
        logic signed [crp_pkg::MulW-1:0] d_x, d_y, d_z;
        st_next.g = dv_reg[crp_pkg::TimeW].g;
        if (dv_reg[crp_pkg::TimeW].sat || (dv_reg[crp_pkg::TimeW].q > horizon))
            st_next.t = horizon;
        else
            st_next.t = dv_reg[crp_pkg::TimeW].q;

        sm_next.chk  = st_reg.g.chk;
        sm_next.rp_x = st_reg.g.rp_x;
        sm_next.rp_y = st_reg.g.rp_y;
        sm_next.rp_z = st_reg.g.rp_z;
        sm_next.comb = st_reg.g.comb;
        sm_next.t    = st_reg.t;
        sm_next.m_x  = st_reg.g.rv_x * $signed({1'b0, st_reg.t});
        sm_next.m_y  = st_reg.g.rv_y * $signed({1'b0, st_reg.t});
        sm_next.m_z  = st_reg.g.rv_z * $signed({1'b0, st_reg.t});

        // divide by 1024 rounding toward zero
        bias_x = sm_reg.m_x[crp_pkg::MulW-1] ? crp_pkg::MulW'((1 << crp_pkg::FracW) - 1) : '0;
        bias_y = sm_reg.m_y[crp_pkg::MulW-1] ? crp_pkg::MulW'((1 << crp_pkg::FracW) - 1) : '0;
        bias_z = sm_reg.m_z[crp_pkg::MulW-1] ? crp_pkg::MulW'((1 << crp_pkg::FracW) - 1) : '0;
        d_x = (sm_reg.m_x + bias_x) >>> crp_pkg::FracW;
        d_y = (sm_reg.m_y + bias_y) >>> crp_pkg::FracW;
        d_z = (sm_reg.m_z + bias_z) >>> crp_pkg::FracW;
        sc_next.chk  = sm_reg.chk;
        sc_next.comb = sm_reg.comb;
        sc_next.t    = sm_reg.t;
        sc_next.c_x  = crp_pkg::CW'(sm_reg.rp_x) + crp_pkg::CW'(d_x);
        sc_next.c_y  = crp_pkg::CW'(sm_reg.rp_y) + crp_pkg::CW'(d_y);
        sc_next.c_z  = crp_pkg::CW'(sm_reg.rp_z) + crp_pkg::CW'(d_z);

        sq_next.chk     = sc_reg.chk;
        sq_next.t       = sc_reg.t;
        sq_next.cc_x    = sc_reg.c_x * sc_reg.c_x;
        sq_next.cc_y    = sc_reg.c_y * sc_reg.c_y;
        sq_next.cc_z    = sc_reg.c_z * sc_reg.c_z;
        sq_next.comb_sq = sc_reg.comb * sc_reg.comb;
    end

    // distance test and digit-by-digit square root, two radicand bits per stage
    always_comb
    begin
        logic [crp_pkg::DsqW-1:0]     dsq;
        logic [crp_pkg::SqRemW-1:0]   rem_sh;
        logic [crp_pkg::SqRemW-1:0]   trial;
        dsq = $unsigned(sq_reg.cc_x) + $unsigned(sq_reg.cc_y) + $unsigned(sq_reg.cc_z);
        rt_next[0].alert = sq_reg.chk && (dsq <= crp_pkg::DsqW'(sq_reg.comb_sq));
        rt_next[0].t     = sq_reg.t;
        rt_next[0].x     = dsq[crp_pkg::SqW-1:0];
        rt_next[0].rem   = '0;
        rt_next[0].root  = '0;
        for (int j = 0; j < crp_pkg::GapW; j++)
        begin
            rem_sh = {rt_reg[j].rem[crp_pkg::SqRemW-3:0],
                      rt_reg[j].x[2*(crp_pkg::GapW-1-j) +: 2]};
            trial  = crp_pkg::SqRemW'({rt_reg[j].root, 2'b01});
            rt_next[j+1] = rt_reg[j];
            if (rem_sh >= trial)
            begin
                rt_next[j+1].rem  = rem_sh - trial;
                rt_next[j+1].root = {rt_reg[j].root[crp_pkg::GapW-2:0], 1'b1};
            end
            else
            begin
                rt_next[j+1].rem  = rem_sh;
                rt_next[j+1].root = {rt_reg[j].root[crp_pkg::GapW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vt_reg <= 1'b0;
            vm_reg <= 1'b0;
            vc_reg <= 1'b0;
            vq_reg <= 1'b0;
            ov_reg <= 1'b0;
            for (int k = 0; k <= crp_pkg::TimeW; k++)
                vd_reg[k] <= 1'b0;
            for (int j = 0; j <= crp_pkg::GapW; j++)
                vr_reg[j] <= 1'b0;
        end
        else if (ce)
        begin
            va_reg    <= !fifo_status.empty;
            vb_reg    <= va_reg;
            vd_reg[0] <= vb_reg;
            for (int k = 0; k < crp_pkg::TimeW; k++)
                vd_reg[k+1] <= vd_reg[k];
            vt_reg    <= vd_reg[crp_pkg::TimeW];
            vm_reg    <= vt_reg;
            vc_reg    <= vm_reg;
            vq_reg    <= vc_reg;
            vr_reg[0] <= vq_reg;
            for (int j = 0; j < crp_pkg::GapW; j++)
                vr_reg[j+1] <= vr_reg[j];
            ov_reg    <= vr_reg[crp_pkg::GapW];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            sa_reg <= sa_next;
            sb_reg <= sb_next;
            for (int k = 0; k <= crp_pkg::TimeW; k++)
                dv_reg[k] <= dv_next[k];
            st_reg <= st_next;
            sm_reg <= sm_next;
            sc_reg <= sc_next;
            sq_reg <= sq_next;
            for (int j = 0; j <= crp_pkg::GapW; j++)
                rt_reg[j] <= rt_next[j];
            out_alert_reg <= rt_reg[crp_pkg::GapW].alert;
            out_time_reg  <= rt_reg[crp_pkg::GapW].alert ? rt_reg[crp_pkg::GapW].t : '0;
            out_gap_reg   <= rt_reg[crp_pkg::GapW].alert ? rt_reg[crp_pkg::GapW].root : '0;
        end
    end

    a_zero_without_alert: assert property (@(posedge clk) disable iff (!rst_n)
        ov_reg && !out_alert_reg |-> (out_time_reg == '0) && (out_gap_reg == '0))
        else $error("result fields not zero without alert");

    a_time_within_horizon: assert property (@(posedge clk) disable iff (!rst_n)
        ov_reg |-> out_time_reg <= horizon)
        else $error("impact time beyond horizon");

    a_root_floor: assert property (@(posedge clk) disable iff (!rst_n)
        vr_reg[crp_pkg::GapW] |->
            ((crp_pkg::SqW+2)'(rt_reg[crp_pkg::GapW].root)
                * (crp_pkg::SqW+2)'(rt_reg[crp_pkg::GapW].root)
                <= (crp_pkg::SqW+2)'(rt_reg[crp_pkg::GapW].x))
            && (((crp_pkg::SqW+2)'(rt_reg[crp_pkg::GapW].root) + 1'b1)
                * ((crp_pkg::SqW+2)'(rt_reg[crp_pkg::GapW].root) + 1'b1)
                > (crp_pkg::SqW+2)'(rt_reg[crp_pkg::GapW].x)))
        else $error("square root not the floor");

endmodule

// ----- rtl/collision_risk_predictor_unit.sv -----
// ----------------------------------------------------------------------------
// collision_risk_predictor_unit
// closest-point-of-approach collision check against a loaded ego vehicle
// ----------------------------------------------------------------------------
// Takes one beat per clock and returns one result beat per input beat, in
// order. A beat with opcode 0 loads the ego (position, velocity, radius) and
// returns an all-zero result; a beat with opcode 1 checks one object against
// the ego. Each beat passes through the front register, an entry of the
// queue and the 36-register back pipeline (two product and sum stages, a
// seed stage and 16 divider stages of one quotient bit each for the
// closest-approach time, four stages of clamp, motion, closest point and
// squaring, a seed stage and 11 square-root stages of one result bit each,
// and the output register). When m_tready drops while the output register
// holds a result, the whole back pipeline holds and the four-entry queue
// plus the front register absorb input, so s_tready falls only once those
// are full.
// Configuration writes are taken every cycle and must be made while no
// result is outstanding.
// ----------------------------------------------------------------------------
module collision_risk_predictor_unit
(
    input  logic                            clk,
    input  logic                            rst_n,
    // input beats
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // pos_x[23:0] pos_y[47:24] pos_z[71:48] vel_x[88:72] vel_y[105:89]
    // vel_z[122:106] radius[132:123] zero[135:133]
    input  logic [crp_pkg::InDataW-1:0]     s_tdata,
    // opcode[0]
    input  logic                            s_tuser,
    // result beats
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // collision_alert[0] impact_time[16:1] closest_gap[27:17] zero[31:28]
    output logic [crp_pkg::OutDataW-1:0]    m_tdata,
    // configuration writes
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [crp_pkg::CfgIdxW-1:0]     cfg_index,
    input  logic [crp_pkg::CfgDataW-1:0]    cfg_data
);

    logic [crp_pkg::TimeW-1:0]      horizon_reg;
    logic [crp_pkg::SpdW-1:0]       min_speed_reg;
    crp_pkg::fifo_status_t          fifo_status;
    crp_pkg::work_t                 front_work;
    crp_pkg::work_t                 back_work;
    logic                           push;
    logic                           pop;
    logic                           out_alert;
    logic [crp_pkg::TimeW-1:0]      out_time;
    logic [crp_pkg::GapW-1:0]       out_gap;

    // register file, always ready; unknown indexes are ignored
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            horizon_reg   <= crp_pkg::HORIZON_RESET;
            min_speed_reg <= crp_pkg::MIN_SPEED_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                crp_pkg::REG_HORIZON:   horizon_reg   <= cfg_data;
                crp_pkg::REG_MIN_SPEED: min_speed_reg <= cfg_data[crp_pkg::SpdW-1:0];
                default: ;
            endcase
        end
    end

    // front: ego state and relative vectors
    crp_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_opcode   (s_tuser),
        .in_pos_x    (s_tdata[23:0]),
        .in_pos_y    (s_tdata[47:24]),
        .in_pos_z    (s_tdata[71:48]),
        .in_vel_x    (s_tdata[88:72]),
        .in_vel_y    (s_tdata[105:89]),
        .in_vel_z    (s_tdata[122:106]),
        .in_radius   (s_tdata[132:123]),
        .min_speed   (min_speed_reg),
        .fifo_status (fifo_status),
        .push        (push),
        .work        (front_work)
    );

    // decoupling queue
    crp_fifo u_fifo
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_data (front_work),
        .pop     (pop),
        .rd_data (back_work),
        .status  (fifo_status)
    );

    // back: time, distance and gap
    crp_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_work     (back_work),
        .fifo_status (fifo_status),
        .pop         (pop),
        .horizon     (horizon_reg),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_alert   (out_alert),
        .out_time    (out_time),
        .out_gap     (out_gap)
    );

    assign m_tdata = {4'b0000, out_gap, out_time, out_alert};

endmodule
